### design/hav_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Haversine distance package
// Shared widths, turn constants and the elaboration-time CORDIC tables.
// ----------------------------------------------------------------------------
package hav_pkg;

  localparam int FRAC_BITS    = 32;
  localparam int CORDIC_STEPS = 32;

  localparam int CW   = FRAC_BITS + 4;      // CORDIC datapath, signed
  localparam int UW   = 34;                 // angle in units of 5e-8 degree
  localparam int MW   = 31;                 // folded angle magnitude
  localparam int SMW  = FRAC_BITS + 1;      // sine/cosine magnitude
  localparam int PRW  = 2 * SMW;            // magnitude products
  localparam int UMW  = SMW + 1;            // rounded cross products
  localparam int HW   = 2 * UMW + 1;        // haversine sum
  localparam int NW   = 2 * FRAC_BITS + 1;  // h and 1-h, up to one
  localparam int RTW  = FRAC_BITS + 1;      // square roots
  localparam int RW   = FRAC_BITS + 5;      // square root remainder
  localparam int ZW   = FRAC_BITS + 2;      // doubled central angle
  localparam int ZH   = ZW / 2;
  localparam int RMW  = 33;                 // radius in millimetres
  localparam int CFGW = 23;
  localparam int OUTW = 35;
  localparam int QS   = 62 - FRAC_BITS;
  localparam int ANG_SHIFT = 93 - FRAC_BITS;

  localparam logic signed [UW-1:0] HALF_TURN    = 34'sd3600000000;
  localparam logic signed [UW-1:0] FULL_TURN    = 34'sd7200000000;
  localparam logic signed [UW-1:0] QUARTER_TURN = 34'sd1800000000;

  localparam logic [63:0] PI_Q62  = 64'hC90FDAA22168C234;
  localparam logic [63:0] RAD_Q93 = ((PI_Q62 / 64'd3600000000) << 31) +
                                    (((PI_Q62 % 64'd3600000000) << 31) / 64'd3600000000);

  localparam logic [RMW-1:0] RADIUS_MM_RESET = 33'd6378137000;
  localparam logic [9:0]     MM_PER_M        = 10'd1000;

  // Q62 product with round half up.
  function automatic logic [63:0] mul_q62(input logic [63:0] a, input logic [63:0] b);
    logic [127:0] pr;
    pr = 128'(a) * 128'(b);
    pr = pr + (128'd1 << 61);
    return pr[125:62];
  endfunction

  // Arctangent of 2^-idx from its power series in Q62, rounded to FRAC_BITS.
  function automatic logic signed [CW-1:0] atan_entry(input int idx);
    logic [63:0] sum;
    logic [63:0] term;
    logic [63:0] rnd;
    int k;
    sum = 64'd0;
    k = 0;
    if (idx == 0) begin
      sum = PI_Q62 >> 2;
    end else begin
      while (idx * (2 * k + 1) <= 62) begin
        term = (64'd1 << (62 - idx * (2 * k + 1))) / 64'(2 * k + 1);
        if ((k & 1) != 0) sum = sum - term;
        else sum = sum + term;
        k++;
      end
    end
    rnd = (sum + (64'd1 << (QS - 1))) >> QS;
    return CW'(rnd);
  endfunction

  // Inverse CORDIC gain by Newton iteration in Q62.
  function automatic logic signed [CW-1:0] cordic_gain();
    logic [63:0] p;
    logic [63:0] y;
    logic [63:0] t;
    logic [63:0] f;
    logic [63:0] three;
    int i;
    p = 64'd1 << 62;
    y = 64'h2666666666666666;
    three = 64'd3 << 62;
    for (i = 0; i < CORDIC_STEPS; i++) begin
      if (2 * i < 64) p = p + (p >> (2 * i));
    end
    for (i = 0; i < 10; i++) begin
      t = mul_q62(p, mul_q62(y, y));
      f = (t < three) ? three - t : 64'd0;
      y = mul_q62(y, f) >> 1;
    end
    return CW'((y + (64'd1 << (QS - 1))) >> QS);
  endfunction

endpackage

### design/hav_sincos.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sine and cosine unit
// Turn reduction, quadrant fold, scaling to radians and a rotation CORDIC
// with one iteration per pipeline stage.
// ----------------------------------------------------------------------------
module hav_sincos (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            en,
  input  logic                            in_vld,
  input  logic signed [hav_pkg::UW-1:0]   angle,
  output logic                            out_vld,
  output logic signed [hav_pkg::CW-1:0]   sine,
  output logic signed [hav_pkg::CW-1:0]   cosine
);

  localparam int N = hav_pkg::CORDIC_STEPS;
  localparam logic signed [hav_pkg::CW-1:0] GAIN = hav_pkg::cordic_gain();

  logic signed [hav_pkg::UW-1:0] wrap;
  logic                          a_vld;
  logic signed [hav_pkg::UW-1:0] a_r;

  logic signed [hav_pkg::UW-1:0] fold_r;
  logic signed [hav_pkg::UW-1:0] fold_abs;
  logic                          fold_flip;
  logic                          b_vld;
  logic                          b_neg;
  logic                          b_flip;
  logic [hav_pkg::MW-1:0]        b_mag;

  logic                          c_vld;
  logic                          c_neg;
  logic                          c_flip;
  logic [62:0]                   c_pl;
  logic [61:0]                   c_ph;

  logic [93:0]                   full;
  logic [93:0]                   rnd;
  logic signed [hav_pkg::CW-1:0] ang;
  logic                          d_vld;
  logic                          d_flip;
  logic signed [hav_pkg::CW-1:0] d_z;

  logic signed [hav_pkg::CW-1:0] cx [N];
  logic signed [hav_pkg::CW-1:0] cy [N];
  logic signed [hav_pkg::CW-1:0] cz [N];
  logic                          cf [N];
  logic                          cv [N];

  // A single wrap suffices as the input never reaches a full turn.
  always_comb begin
    if (angle > hav_pkg::HALF_TURN) wrap = angle - hav_pkg::FULL_TURN;
    else if (angle < -hav_pkg::HALF_TURN) wrap = angle + hav_pkg::FULL_TURN;
    else wrap = angle;
  end

  always_comb begin
    fold_flip = 1'b1;
    if (a_r > hav_pkg::QUARTER_TURN) fold_r = hav_pkg::HALF_TURN - a_r;
    else if (a_r < -hav_pkg::QUARTER_TURN) fold_r = -hav_pkg::HALF_TURN - a_r;
    else begin
      fold_r = a_r;
      fold_flip = 1'b0;
    end
    fold_abs = (fold_r < 0) ? -fold_r : fold_r;
  end

  always_comb begin
    full = {c_ph, 32'b0} + 94'(c_pl);
    rnd  = full + (94'd1 << (hav_pkg::ANG_SHIFT - 1));
    ang  = hav_pkg::CW'(rnd >> hav_pkg::ANG_SHIFT);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_vld <= 1'b0;
      b_vld <= 1'b0;
      c_vld <= 1'b0;
      d_vld <= 1'b0;
    end else if (en) begin
      a_vld <= in_vld;
      b_vld <= a_vld;
      c_vld <= b_vld;
      d_vld <= c_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_r    <= wrap;
      b_neg  <= fold_r < 0;
      b_flip <= fold_flip;
      b_mag  <= fold_abs[hav_pkg::MW-1:0];
      c_neg  <= b_neg;
      c_flip <= b_flip;
      c_pl   <= b_mag * hav_pkg::RAD_Q93[31:0];
      c_ph   <= b_mag * hav_pkg::RAD_Q93[62:32];
      d_flip <= c_flip;
      d_z    <= c_neg ? -ang : ang;
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_it
    localparam logic signed [hav_pkg::CW-1:0] ATAN = hav_pkg::atan_entry(i);
    logic signed [hav_pkg::CW-1:0] xi;
    logic signed [hav_pkg::CW-1:0] yi;
    logic signed [hav_pkg::CW-1:0] zi;
    logic                          fi;
    logic                          vi;

    if (i == 0) begin : g_first
      assign xi = GAIN;
      assign yi = '0;
      assign zi = d_z;
      assign fi = d_flip;
      assign vi = d_vld;
    end else begin : g_next
      assign xi = cx[i-1];
      assign yi = cy[i-1];
      assign zi = cz[i-1];
      assign fi = cf[i-1];
      assign vi = cv[i-1];
    end

    always_ff @(posedge clk) begin
      if (rst) cv[i] <= 1'b0;
      else if (en) cv[i] <= vi;
    end

    always_ff @(posedge clk) begin
      if (en) begin
        cf[i] <= fi;
        if (zi >= 0) begin
          cx[i] <= xi - (yi >>> i);
          cy[i] <= yi + (xi >>> i);
          cz[i] <= zi - ATAN;
        end else begin
          cx[i] <= xi + (yi >>> i);
          cy[i] <= yi - (xi >>> i);
          cz[i] <= zi + ATAN;
        end
      end
    end
  end

  assign out_vld = cv[N-1];
  assign sine    = cy[N-1];
  assign cosine  = cf[N-1] ? -cx[N-1] : cx[N-1];

endmodule

### design/hav_sqrt.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Square root unit
// Restoring integer square root, one result bit per pipeline stage, truncated.
// ----------------------------------------------------------------------------
module hav_sqrt (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        en,
  input  logic                        in_vld,
  input  logic [hav_pkg::NW-1:0]      radicand,
  output logic                        out_vld,
  output logic [hav_pkg::RTW-1:0]     root
);

  localparam int N  = hav_pkg::RTW;
  localparam int DW = 2 * hav_pkg::RTW;

  logic [DW-1:0]          sn [N];
  logic [hav_pkg::RW-1:0] sr [N];
  logic [N-1:0]           sq [N];
  logic                   sv [N];

  for (genvar i = 0; i < N; i++) begin : g_bit
    logic [DW-1:0]          ni;
    logic [hav_pkg::RW-1:0] ri;
    logic [N-1:0]           qi;
    logic                   vi;
    logic [hav_pkg::RW-1:0] rem_sh;
    logic [hav_pkg::RW-1:0] trial;
    logic                   ge;

    if (i == 0) begin : g_first
      assign ni = DW'(radicand);
      assign ri = '0;
      assign qi = '0;
      assign vi = in_vld;
    end else begin : g_next
      assign ni = sn[i-1];
      assign ri = sr[i-1];
      assign qi = sq[i-1];
      assign vi = sv[i-1];
    end

    assign rem_sh = {ri[hav_pkg::RW-3:0], ni[DW-1 -: 2]};
    assign trial  = hav_pkg::RW'({qi, 2'b01});
    assign ge     = rem_sh >= trial;

    always_ff @(posedge clk) begin
      if (rst) sv[i] <= 1'b0;
      else if (en) sv[i] <= vi;
    end

    always_ff @(posedge clk) begin
      if (en) begin
        sn[i] <= ni << 2;
        sr[i] <= ge ? rem_sh - trial : rem_sh;
        sq[i] <= {qi[N-2:0], ge};
      end
    end
  end

  assign out_vld = sv[N-1];
  assign root    = sq[N-1];

endmodule

### design/hav_atan.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Arctangent unit
// Vectoring CORDIC giving atan2(y, x) for non-negative x and y, one iteration
// per pipeline stage, negative results clamped to zero.
// ----------------------------------------------------------------------------
module hav_atan (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          en,
  input  logic                          in_vld,
  input  logic [hav_pkg::RTW-1:0]       x_in,
  input  logic [hav_pkg::RTW-1:0]       y_in,
  output logic                          out_vld,
  output logic [hav_pkg::ZW-2:0]        angle
);

  localparam int N = hav_pkg::CORDIC_STEPS;

  logic signed [hav_pkg::CW-1:0] vx [N];
  logic signed [hav_pkg::CW-1:0] vy [N];
  logic signed [hav_pkg::CW-1:0] vz [N];
  logic                          vv [N];

  for (genvar i = 0; i < N; i++) begin : g_it
    localparam logic signed [hav_pkg::CW-1:0] ATAN = hav_pkg::atan_entry(i);
    logic signed [hav_pkg::CW-1:0] xi;
    logic signed [hav_pkg::CW-1:0] yi;
    logic signed [hav_pkg::CW-1:0] zi;
    logic                          vi;

    if (i == 0) begin : g_first
      assign xi = hav_pkg::CW'(x_in);
      assign yi = hav_pkg::CW'(y_in);
      assign zi = '0;
      assign vi = in_vld;
    end else begin : g_next
      assign xi = vx[i-1];
      assign yi = vy[i-1];
      assign zi = vz[i-1];
      assign vi = vv[i-1];
    end

    always_ff @(posedge clk) begin
      if (rst) vv[i] <= 1'b0;
      else if (en) vv[i] <= vi;
    end

    always_ff @(posedge clk) begin
      if (en) begin
        if (yi > 0) begin
          vx[i] <= xi + (yi >>> i);
          vy[i] <= yi - (xi >>> i);
          vz[i] <= zi + ATAN;
        end else begin
          vx[i] <= xi - (yi >>> i);
          vy[i] <= yi + (xi >>> i);
          vz[i] <= zi - ATAN;
        end
      end
    end
  end

  assign out_vld = vv[N-1];
  assign angle   = (vz[N-1] < 0) ? '0 : vz[N-1][hav_pkg::ZW-2:0];

endmodule

### design/haversine_distance.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Haversine great-circle distance
// Distance in millimetres between two positions given in 1e-7 degree.
// ----------------------------------------------------------------------------
// A beat on the s_axis channel carries two positions; one beat on m_axis
// carries the rounded distance. The cfg channel writes the earth radius in
// metres and is always ready; write it only while no beat is in flight.
// Four rotation CORDICs give the sines and cosines, then the haversine is
// formed, two digit-by-digit square roots and a vectoring CORDIC give the
// central angle, and a split multiply scales it by the radius.
// One beat is accepted every cycle while the skid register is empty; the
// CORDIC and square root stages each do one iteration per register stage.
// The pipeline moves as a whole. A result that cannot be delivered goes to
// a one-beat skid register, and s_axis_tready drops only while that register
// is full, so a stalled receiver loses and repeats nothing.
// Reset empties the pipeline and loads a radius of 6378137 m.
// ----------------------------------------------------------------------------
module haversine_distance (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     s_axis_tvalid,
  output logic                     s_axis_tready,
  // from_lat[30:0], from_lon[62:31], to_lat[93:63], to_lon[125:94]
  input  logic [127:0]             s_axis_tdata,
  output logic                     m_axis_tvalid,
  input  logic                     m_axis_tready,
  // distance_mm[34:0]
  output logic [39:0]              m_axis_tdata,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [hav_pkg::CFGW-1:0] cfg_data
);

  logic en;

  logic signed [30:0] from_lat;
  logic signed [31:0] from_lon;
  logic signed [30:0] to_lat;
  logic signed [31:0] to_lon;

  logic [hav_pkg::RMW-1:0] radius_mm;

  logic                          in_vld;
  logic signed [hav_pkg::UW-1:0] in_dlat;
  logic signed [hav_pkg::UW-1:0] in_dlon;
  logic signed [hav_pkg::UW-1:0] in_lat1;
  logic signed [hav_pkg::UW-1:0] in_lat2;

  logic                          sc_vld;
  logic signed [hav_pkg::CW-1:0] s1;
  logic signed [hav_pkg::CW-1:0] s2;
  logic signed [hav_pkg::CW-1:0] c1;
  logic signed [hav_pkg::CW-1:0] c2;
  logic signed [hav_pkg::CW-1:0] unused_c0;
  logic signed [hav_pkg::CW-1:0] unused_c1;
  logic signed [hav_pkg::CW-1:0] unused_s2;
  logic signed [hav_pkg::CW-1:0] unused_s3;

  logic signed [hav_pkg::CW-1:0] s1_abs;
  logic signed [hav_pkg::CW-1:0] s2_abs;
  logic signed [hav_pkg::CW-1:0] c1_abs;
  logic signed [hav_pkg::CW-1:0] c2_abs;

  logic                     p1_vld;
  logic                     p1_su;
  logic                     p1_sv;
  logic [hav_pkg::PRW-1:0]  p1_a;
  logic [hav_pkg::PRW-1:0]  p1_pu;
  logic [hav_pkg::PRW-1:0]  p1_pv;

  logic [hav_pkg::PRW:0]    u_rnd;
  logic [hav_pkg::PRW:0]    v_rnd;
  logic [hav_pkg::UMW-1:0]  u_mag;
  logic [hav_pkg::UMW-1:0]  v_mag;
  logic                     p2_vld;
  logic                     p2_uneg;
  logic                     p2_vneg;
  logic [hav_pkg::PRW-1:0]  p2_a;
  logic [hav_pkg::UMW-1:0]  p2_u;
  logic [hav_pkg::UMW-1:0]  p2_v;

  logic                     p3_vld;
  logic                     p3_diff;
  logic [hav_pkg::PRW-1:0]  p3_a;
  logic [2*hav_pkg::UMW-1:0] p3_b;

  logic [hav_pkg::HW-1:0]   hav_sum;
  logic [hav_pkg::HW-1:0]   hav_clamp;
  logic [hav_pkg::HW-1:0]   hav_one;
  logic                     p4_vld;
  logic [hav_pkg::NW-1:0]   p4_n;
  logic [hav_pkg::NW-1:0]   p4_q;

  logic                     sq_vld;
  logic [hav_pkg::RTW-1:0]  root_h;
  logic [hav_pkg::RTW-1:0]  root_q;

  logic                     at_vld;
  logic [hav_pkg::ZW-2:0]   cangle;
  logic [hav_pkg::ZW-1:0]   z2;

  logic                             sf_vld;
  logic [hav_pkg::ZH+hav_pkg::RMW-1:0] sf_pl;
  logic [hav_pkg::ZH+hav_pkg::RMW-1:0] sf_ph;
  logic [hav_pkg::ZW+hav_pkg::RMW:0]   dist_sum;
  logic [hav_pkg::OUTW-1:0]            dist_mm;

  logic                     out_vld;
  logic [hav_pkg::OUTW-1:0] out_data;
  logic                     skid_vld;
  logic [hav_pkg::OUTW-1:0] skid_data;

  assign from_lat = s_axis_tdata[30:0];
  assign from_lon = s_axis_tdata[62:31];
  assign to_lat   = s_axis_tdata[93:63];
  assign to_lon   = s_axis_tdata[125:94];

  // The pipeline advances whenever the skid register is free.
  assign en            = !skid_vld;
  assign s_axis_tready = en;
  assign cfg_ready     = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) radius_mm <= hav_pkg::RADIUS_MM_RESET;
    else if (cfg_valid) radius_mm <= hav_pkg::RMW'(cfg_data) * hav_pkg::RMW'(hav_pkg::MM_PER_M);
  end

  // Input stage: half differences and doubled latitudes in 5e-8 degree.
  always_ff @(posedge clk) begin
    if (rst) in_vld <= 1'b0;
    else if (en) in_vld <= s_axis_tvalid;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      in_dlat <= hav_pkg::UW'(from_lat) - hav_pkg::UW'(to_lat);
      in_dlon <= hav_pkg::UW'(from_lon) - hav_pkg::UW'(to_lon);
      in_lat1 <= hav_pkg::UW'(from_lat) <<< 1;
      in_lat2 <= hav_pkg::UW'(to_lat) <<< 1;
    end
  end

  hav_sincos u_sc_dlat (
    .clk, .rst, .en, .in_vld(in_vld), .angle(in_dlat),
    .out_vld(sc_vld), .sine(s1), .cosine(unused_c0)
  );

  hav_sincos u_sc_dlon (
    .clk, .rst, .en, .in_vld(in_vld), .angle(in_dlon),
    .out_vld(), .sine(s2), .cosine(unused_c1)
  );

  hav_sincos u_sc_lat1 (
    .clk, .rst, .en, .in_vld(in_vld), .angle(in_lat1),
    .out_vld(), .sine(unused_s2), .cosine(c1)
  );

  hav_sincos u_sc_lat2 (
    .clk, .rst, .en, .in_vld(in_vld), .angle(in_lat2),
    .out_vld(), .sine(unused_s3), .cosine(c2)
  );

  assign s1_abs = (s1 < 0) ? -s1 : s1;
  assign s2_abs = (s2 < 0) ? -s2 : s2;
  assign c1_abs = (c1 < 0) ? -c1 : c1;
  assign c2_abs = (c2 < 0) ? -c2 : c2;

  // Products are taken on magnitudes, with the sign put back after rounding.
  assign u_rnd = hav_pkg::PRW'(p1_pu) + ((hav_pkg::PRW+1)'(1) << (hav_pkg::FRAC_BITS - 1));
  assign v_rnd = hav_pkg::PRW'(p1_pv) + ((hav_pkg::PRW+1)'(1) << (hav_pkg::FRAC_BITS - 1));
  assign u_mag = hav_pkg::UMW'(u_rnd >> hav_pkg::FRAC_BITS);
  assign v_mag = hav_pkg::UMW'(v_rnd >> hav_pkg::FRAC_BITS);

  assign hav_one = hav_pkg::HW'(1) << (2 * hav_pkg::FRAC_BITS);

  always_comb begin
    if (p3_diff) begin
      hav_sum = (hav_pkg::HW'(p3_b) <= hav_pkg::HW'(p3_a)) ?
                hav_pkg::HW'(p3_a) - hav_pkg::HW'(p3_b) : '0;
    end else begin
      hav_sum = hav_pkg::HW'(p3_a) + hav_pkg::HW'(p3_b);
    end
    hav_clamp = (hav_sum > hav_one) ? hav_one : hav_sum;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p1_vld <= 1'b0;
      p2_vld <= 1'b0;
      p3_vld <= 1'b0;
      p4_vld <= 1'b0;
    end else if (en) begin
      p1_vld <= sc_vld;
      p2_vld <= p1_vld;
      p3_vld <= p2_vld;
      p4_vld <= p3_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p1_su   <= (s2 < 0) ^ (c1 < 0);
      p1_sv   <= (s2 < 0) ^ (c2 < 0);
      p1_a    <= s1_abs[hav_pkg::SMW-1:0] * s1_abs[hav_pkg::SMW-1:0];
      p1_pu   <= s2_abs[hav_pkg::SMW-1:0] * c1_abs[hav_pkg::SMW-1:0];
      p1_pv   <= s2_abs[hav_pkg::SMW-1:0] * c2_abs[hav_pkg::SMW-1:0];
      p2_a    <= p1_a;
      p2_u    <= u_mag;
      p2_v    <= v_mag;
      p2_uneg <= p1_su && (u_mag != '0);
      p2_vneg <= p1_sv && (v_mag != '0);
      p3_a    <= p2_a;
      p3_b    <= p2_u * p2_v;
      p3_diff <= p2_uneg != p2_vneg;
      p4_n    <= hav_pkg::NW'(hav_clamp);
      p4_q    <= hav_pkg::NW'(hav_one - hav_clamp);
    end
  end

  hav_sqrt u_sqrt_h (
    .clk, .rst, .en, .in_vld(p4_vld), .radicand(p4_n),
    .out_vld(sq_vld), .root(root_h)
  );

  hav_sqrt u_sqrt_q (
    .clk, .rst, .en, .in_vld(p4_vld), .radicand(p4_q),
    .out_vld(), .root(root_q)
  );

  hav_atan u_atan (
    .clk, .rst, .en, .in_vld(sq_vld), .x_in(root_q), .y_in(root_h),
    .out_vld(at_vld), .angle(cangle)
  );

  // Scaling: twice the angle times the radius, split into two partial products.
  assign z2 = {cangle, 1'b0};

  always_ff @(posedge clk) begin
    if (rst) sf_vld <= 1'b0;
    else if (en) sf_vld <= at_vld;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sf_pl <= z2[hav_pkg::ZH-1:0] * radius_mm;
      sf_ph <= z2[hav_pkg::ZW-1:hav_pkg::ZH] * radius_mm;
    end
  end

  assign dist_sum = ((hav_pkg::ZW+hav_pkg::RMW+1)'(sf_ph) << hav_pkg::ZH) +
                    (hav_pkg::ZW+hav_pkg::RMW+1)'(sf_pl) +
                    ((hav_pkg::ZW+hav_pkg::RMW+1)'(1) << (hav_pkg::FRAC_BITS - 1));
  assign dist_mm = hav_pkg::OUTW'(dist_sum >> hav_pkg::FRAC_BITS);

  // Output register with a one-beat skid behind it.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld  <= 1'b0;
      skid_vld <= 1'b0;
    end else if (out_vld && !m_axis_tready) begin
      if (en && sf_vld) skid_vld <= 1'b1;
    end else if (skid_vld) begin
      out_vld  <= 1'b1;
      skid_vld <= 1'b0;
    end else begin
      out_vld <= sf_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (out_vld && !m_axis_tready) begin
      if (en && sf_vld) skid_data <= dist_mm;
    end else if (skid_vld) begin
      out_data <= skid_data;
    end else begin
      out_data <= dist_mm;
    end
  end

  assign m_axis_tvalid = out_vld;
  assign m_axis_tdata  = {5'b0, out_data};

  a_skid_needs_out: assert property (@(posedge clk) disable iff (rst)
    skid_vld |-> out_vld)
    else $error("skid register full while output register empty");

  a_skid_fill: assert property (@(posedge clk) disable iff (rst)
    $rose(skid_vld) |-> $past(out_vld && !m_axis_tready))
    else $error("skid register filled without a stalled output");

  a_skid_drain: assert property (@(posedge clk) disable iff (rst)
    skid_vld && m_axis_tready |=> out_vld && !skid_vld)
    else $error("skid register did not drain into the output register");

  a_radius_reset: assert property (@(posedge clk)
    rst |=> radius_mm == hav_pkg::RADIUS_MM_RESET)
    else $error("radius not restored by reset");

endmodule
